/* rtl/ghst_pkg.sv */
`timescale 1ns / 1ps

package ghst_pkg;

   // table geometry
   localparam int SLOTS          = 16;
   localparam int MIXER_CHANNELS = 32;
   localparam int SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // field widths
   localparam int OP_W      = 3;
   localparam int HANDLE_W  = 16;
   localparam int SID_W     = 16;
   localparam int VOL_W     = 8;
   localparam int GEN_W     = 8;
   localparam int CH_W      = 5;
   localparam int MIXP_W    = CH_W + 1;
   localparam int CHMASK_W  = 32;
   localparam int SCLEAR_W  = 16;
   localparam int MASTER_W  = 11;
   localparam int MUL_W     = VOL_W + MASTER_W;
   localparam int VOL_SHIFT = 10;
   localparam logic [MASTER_W-1:0] MASTER_MAX = MASTER_W'(1 << VOL_SHIFT);

   // request beat layout
   localparam int REQ_HANDLE_LO = 0;
   localparam int REQ_SID_LO    = REQ_HANDLE_LO + HANDLE_W;
   localparam int REQ_VOL_LO    = REQ_SID_LO + SID_W;
   localparam int REQ_GV_BIT    = REQ_VOL_LO + VOL_W;
   localparam int REQ_GCH_LO    = REQ_GV_BIT + 1;
   localparam int REQ_ENDED_LO  = REQ_GCH_LO + CH_W;
   localparam int REQ_USED_W    = REQ_ENDED_LO + CHMASK_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // response beat layout
   localparam int RSP_HANDLE_LO = 0;
   localparam int RSP_MCH_LO    = RSP_HANDLE_LO + HANDLE_W;
   localparam int RSP_SVOL_LO   = RSP_MCH_LO + CH_W;
   localparam int RSP_TAKEN_BIT = RSP_SVOL_LO + VOL_W;
   localparam int RSP_MFREE_LO  = RSP_TAKEN_BIT + 1;
   localparam int RSP_SCLEAR_LO = RSP_MFREE_LO + CHMASK_W;
   localparam int RSP_USED_W    = RSP_SCLEAR_LO + SCLEAR_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   // csr port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_COUNT  = 1'b0,
      CSR_MASTER_VOLUME = 1'b1
   } csr_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_PLAY        = 3'd0,
      OP_QUERY       = 3'd1,
      OP_SET_VOLUME  = 3'd2,
      OP_CANCEL      = 3'd3,
      OP_RELEASE     = 3'd4,
      OP_CANCEL_ALL  = 3'd5,
      OP_UPDATE      = 3'd6
   } op_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

/* rtl/generation_handle_slot_table.sv */
`timescale 1ns / 1ps
// A request beat is captured into the request registers, and the execute step writes
// its result beat into the output register once that register is free.
// Each request takes a capture step and an execute step that reads and rewrites
// the slot table; one request is in flight at a time, none taken until it executes.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears the slot table, busy mask, generation
// counter and both configuration registers.

module generation_handle_slot_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // handle, sample_num, volume, grant_valid, grant_channel, ended_mask
   input  logic [ghst_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // op
   input  logic [ghst_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // handle_out, mixer_chan, scaled_volume, grant_taken, mixer_free_mask,
   // slot_clear_mask
   output logic [ghst_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // ok
   output logic                              rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [ghst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ghst_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ghst_pkg::*;

   cmd_type cmd;

   ghst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ghst_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_op    (req_tuser),
      .req_data  (req_tdata),
      .rsp_ok    (rsp_tuser),
      .rsp_data  (rsp_tdata)
   );

endmodule

/* rtl/ghst_ctrl.sv */
`timescale 1ns / 1ps

module ghst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ghst_pkg::cmd_type cmd
);
   import ghst_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold the beat until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/ghst_dpath.sv */
`timescale 1ns / 1ps

module ghst_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  ghst_pkg::cmd_type                 cmd,
   input  logic                              csr_wr_en,
   input  logic [ghst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ghst_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [ghst_pkg::OP_W-1:0]         req_op,
   input  logic [ghst_pkg::REQ_TDATA_W-1:0]  req_data,
   output logic                              rsp_ok,
   output logic [ghst_pkg::RSP_TDATA_W-1:0]  rsp_data
);
   import ghst_pkg::*;

   // configuration
   logic [SID_W-1:0]    sample_count_ff;
   logic [MASTER_W-1:0] master_ff;
   logic [MASTER_W-1:0] master_wr;

   // captured request
   op_type                op_ff;
   logic [HANDLE_W-1:0]   handle_ff;
   logic [SID_W-1:0]      sid_ff;
   logic [VOL_W-1:0]      vol_ff;
   logic                  gv_ff;
   logic [CH_W-1:0]       gch_ff;
   logic [CHMASK_W-1:0]   ended_ff;

   // slot table
   logic [GEN_W-1:0]  gen_ff  [SLOTS];
   logic [GEN_W-1:0]  gen_in  [SLOTS];
   logic [MIXP_W-1:0] mixp_ff [SLOTS];
   logic [MIXP_W-1:0] mixp_in [SLOTS];
   logic [SLOTS-1:0]  busy_ff, busy_in;
   logic [GEN_W-1:0]  ngen_ff, ngen_in;

   // lookups
   logic [7:0]        hlow, hgen, hidx8;
   logic              hin_range, hvalid;
   logic [SLOT_W-1:0] hs;
   logic [CH_W-1:0]   hch;
   logic [SLOT_W-1:0] free_idx;
   logic              free_any;
   logic              grant_ok, sid_ok;
   logic [MUL_W-1:0]  prod;
   logic [VOL_W-1:0]  scaled;

   // result
   logic                ok_in;
   logic [HANDLE_W-1:0] hout_in;
   logic [CH_W-1:0]     mch_in;
   logic [VOL_W-1:0]    svol_in;
   logic                taken_in;
   logic [CHMASK_W-1:0] mfree_in;
   logic [SLOTS-1:0]    sclear_in, keep;
   logic [31:0]         sclear_wide;
   logic                rsp_ok_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   assign master_wr = (csr_wdata[MASTER_W-1:0] > MASTER_MAX) ? MASTER_MAX
                                                            : csr_wdata[MASTER_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
         master_ff       <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_COUNT:  sample_count_ff <= csr_wdata[SID_W-1:0];
            CSR_MASTER_VOLUME: master_ff       <= master_wr;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= op_type'(req_op);
         handle_ff <= req_data[REQ_HANDLE_LO +: HANDLE_W];
         sid_ff    <= req_data[REQ_SID_LO +: SID_W];
         vol_ff    <= req_data[REQ_VOL_LO +: VOL_W];
         gv_ff     <= req_data[REQ_GV_BIT];
         gch_ff    <= req_data[REQ_GCH_LO +: CH_W];
         ended_ff  <= req_data[REQ_ENDED_LO +: CHMASK_W];
      end
   end

   // handle check: low byte is slot plus one, high byte the generation
   assign hlow      = handle_ff[7:0];
   assign hgen      = handle_ff[15:8];
   assign hidx8     = hlow - 8'd1;
   assign hin_range = (hlow != 8'd0) && (hidx8 < 8'(SLOTS));
   assign hs        = hidx8[SLOT_W-1:0];
   assign hvalid    = hin_range && (gen_ff[hs] == hgen) && (mixp_ff[hs] != '0);
   assign hch       = CH_W'(mixp_ff[hs] - MIXP_W'(1));

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) free_idx = SLOT_W'(i);
      end
   end
   assign free_any = ~&busy_ff;

   assign grant_ok = gv_ff && ({1'b0, gch_ff} < MIXP_W'(MIXER_CHANNELS));
   assign sid_ok   = sid_ff < sample_count_ff;
   assign prod     = MUL_W'(vol_ff) * MUL_W'(master_ff);
   assign scaled   = VOL_W'(prod >> VOL_SHIFT);

   always_comb begin
      gen_in    = gen_ff;
      mixp_in   = mixp_ff;
      busy_in   = busy_ff;
      ngen_in   = ngen_ff;
      ok_in     = 1'b0;
      hout_in   = '0;
      mch_in    = '0;
      svol_in   = '0;
      taken_in  = 1'b0;
      mfree_in  = '0;
      sclear_in = '0;
      keep      = '0;
      unique case (op_ff)
         OP_PLAY: begin
            if (sid_ok) begin
               if (hvalid) begin
                  busy_in[hs] = 1'b1;
                  ok_in       = 1'b1;
                  hout_in     = handle_ff;
                  mch_in      = hch;
                  svol_in     = scaled;
               end else if (free_any && grant_ok) begin
                  gen_in[free_idx]  = ngen_ff;
                  mixp_in[free_idx] = MIXP_W'(gch_ff) + MIXP_W'(1);
                  busy_in[free_idx] = 1'b1;
                  hout_in           = {ngen_ff, 8'(free_idx) + 8'd1};
                  ngen_in           = ngen_ff + GEN_W'(1);
                  ok_in             = 1'b1;
                  mch_in            = gch_ff;
                  taken_in          = 1'b1;
                  svol_in           = scaled;
               end
            end
         end
         OP_QUERY, OP_SET_VOLUME, OP_CANCEL, OP_RELEASE: begin
            if (hvalid) begin
               ok_in  = 1'b1;
               mch_in = hch;
               if (op_ff == OP_SET_VOLUME) begin
                  svol_in = scaled;
               end else if (op_ff == OP_CANCEL || op_ff == OP_RELEASE) begin
                  mfree_in[hch] = 1'b1;
                  sclear_in[hs] = busy_ff[hs];
                  gen_in[hs]    = '0;
                  mixp_in[hs]   = '0;
                  busy_in[hs]   = 1'b0;
               end
            end
         end
         OP_CANCEL_ALL: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (busy_ff[s] && mixp_ff[s] != '0)
                  mfree_in[CH_W'(mixp_ff[s] - MIXP_W'(1))] = 1'b1;
               gen_in[s]  = '0;
               mixp_in[s] = '0;
            end
            sclear_in = busy_ff;
            busy_in   = '0;
            ok_in     = 1'b1;
         end
         OP_UPDATE: begin
            // free slots whose mixer channel ended; a busy slot without one drops out
            for (int s = 0; s < SLOTS; s++) begin
               if (busy_ff[s] && mixp_ff[s] != '0) begin
                  if (ended_ff[CH_W'(mixp_ff[s] - MIXP_W'(1))]) begin
                     mfree_in[CH_W'(mixp_ff[s] - MIXP_W'(1))] = 1'b1;
                     gen_in[s]  = '0;
                     mixp_in[s] = '0;
                  end else begin
                     keep[s] = 1'b1;
                  end
               end
            end
            sclear_in = busy_ff & ~keep;
            busy_in   = keep;
            ok_in     = 1'b1;
         end
         default: ;
      endcase
   end

   assign sclear_wide = 32'(sclear_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            gen_ff[s]  <= '0;
            mixp_ff[s] <= '0;
         end
         busy_ff <= '0;
         ngen_ff <= '0;
      end else if (cmd.execute) begin
         gen_ff  <= gen_in;
         mixp_ff <= mixp_in;
         busy_ff <= busy_in;
         ngen_ff <= ngen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ok_ff   <= ok_in;
         rsp_data_ff <= RSP_TDATA_W'({sclear_wide[SCLEAR_W-1:0], mfree_in, taken_in,
                                      svol_in, mch_in, hout_in});
      end
   end

   assign rsp_ok   = rsp_ok_ff;
   assign rsp_data = rsp_data_ff;

endmodule

/* rtl/ghst_checker.sv */
`timescale 1ns / 1ps

module ghst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ghst_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser
);
   import ghst_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // one request in flight: no accept right after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is still executing");

   // a failed result carries no handle and takes no grant
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[RSP_HANDLE_LO +: HANDLE_W] == '0 && !rsp_tdata[RSP_TAKEN_BIT])
      else $error("failed result carries a handle or grant");

   // a taken grant always comes with a fresh handle naming a slot
   a_grant_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_TAKEN_BIT] |->
         rsp_tuser && rsp_tdata[RSP_HANDLE_LO +: 8] != 8'd0)
      else $error("grant taken without a valid handle");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind generation_handle_slot_table ghst_checker u_ghst_checker (.*);
